/* rtl/core/pdu_pkg.sv */
// Package: shared payload types, status codes and queue sizing for the percent decoder.
package pdu_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7F;

    localparam logic [7:0] U8_CONT_LO = 8'h80;
    localparam logic [7:0] U8_CONT_HI = 8'hBF;
    localparam logic [7:0] U8_LEAD2_LO = 8'hC2;
    localparam logic [7:0] U8_LEAD2_HI = 8'hDF;
    localparam logic [7:0] U8_LEAD3_LO = 8'hE0;
    localparam logic [7:0] U8_LEAD3_HI = 8'hEF;
    localparam logic [7:0] U8_LEAD4_LO = 8'hF0;
    localparam logic [7:0] U8_LEAD4_HI = 8'hF4;
    localparam logic [7:0] U8_E0_MIN  = 8'hA0;
    localparam logic [7:0] U8_ED      = 8'hED;
    localparam logic [7:0] U8_ED_MAX  = 8'h9F;
    localparam logic [7:0] U8_F0_MIN  = 8'h90;
    localparam logic [7:0] U8_F4_MAX  = 8'h8F;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_BAD_ESCAPE = 3'd3,
        ST_CONTROL    = 3'd4,
        ST_BAD_UTF8   = 3'd5
    } t_status;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       no_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       final_mark;
    } t_out_item;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       has_status;
        t_status    status;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

/* rtl/core/pdu_front.sv */
// Front end: accepts encoded bytes, decodes escapes, validates UTF-8 and forms queue entries.
module pdu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  pdu_pkg::t_in_item i_item,
    output pdu_pkg::t_push    o_push
);

    typedef enum logic [2:0] {
        PH_OUT = 3'b001,
        PH_HI  = 3'b010,
        PH_LO  = 3'b100
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_high, n_high;
    logic             r_fdb, n_fdb;
    pdu_pkg::t_status r_err, n_err;
    logic [1:0]       r_pend, n_pend;
    logic             r_expect, n_expect;
    logic [7:0]       r_lo, n_lo;
    logic [7:0]       r_hi, n_hi;
    logic             r_seen, n_seen;

    logic             hex_bad;
    logic [3:0]       hex_nib;
    logic             have_value;
    logic [7:0]       value;
    logic             u8_bad;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic pdu_pkg::t_status fault(input pdu_pkg::t_status cur,
                                               input pdu_pkg::t_status code);
        pdu_pkg::t_status r;
        r = cur;
        if (cur == pdu_pkg::ST_OK || cur == pdu_pkg::ST_BAD_UTF8) begin
            r = code;
        end
        return r;
    endfunction

    assign {hex_bad, hex_nib} = hex_decode(i_item.in_byte);

    always_comb begin
        n_phase    = r_phase;
        n_high     = r_high;
        n_fdb      = r_fdb;
        n_err      = r_err;
        n_pend     = r_pend;
        n_expect   = r_expect;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_seen     = r_seen;
        have_value = 1'b0;
        value      = i_item.in_byte;
        u8_bad     = 1'b0;
        o_push     = '0;

        if (!i_item.no_byte) begin
            n_seen = 1'b1;
            unique case (r_phase)
                PH_HI: begin
                    n_fdb   = hex_bad;
                    n_high  = hex_nib;
                    n_phase = PH_LO;
                end
                PH_LO: begin
                    n_phase = PH_OUT;
                    if (r_fdb || hex_bad) begin
                        n_err = fault(n_err, pdu_pkg::ST_BAD_ESCAPE);
                    end else begin
                        value      = {r_high, hex_nib};
                        have_value = 1'b1;
                    end
                    n_fdb = 1'b0;
                end
                default: begin
                    if (i_item.in_byte == pdu_pkg::CH_PERCENT) begin
                        n_phase = PH_HI;
                    end else begin
                        n_phase    = PH_OUT;
                        have_value = 1'b1;
                    end
                end
            endcase
        end

        if (have_value) begin
            if (value < pdu_pkg::CH_SPACE || value == pdu_pkg::CH_DEL) begin
                n_err = fault(n_err, pdu_pkg::ST_CONTROL);
            end else if (n_err == pdu_pkg::ST_OK) begin
                if (r_pend == 2'd0) begin
                    if (value > pdu_pkg::CH_DEL) begin
                        n_lo = pdu_pkg::U8_CONT_LO;
                        n_hi = pdu_pkg::U8_CONT_HI;
                        if (value >= pdu_pkg::U8_LEAD2_LO && value <= pdu_pkg::U8_LEAD2_HI) begin
                            n_pend   = 2'd1;
                            n_expect = 1'b1;
                        end else if (value >= pdu_pkg::U8_LEAD3_LO &&
                                     value <= pdu_pkg::U8_LEAD3_HI) begin
                            n_pend   = 2'd2;
                            n_expect = 1'b1;
                            if (value == pdu_pkg::U8_LEAD3_LO) n_lo = pdu_pkg::U8_E0_MIN;
                            if (value == pdu_pkg::U8_ED) n_hi = pdu_pkg::U8_ED_MAX;
                        end else if (value >= pdu_pkg::U8_LEAD4_LO &&
                                     value <= pdu_pkg::U8_LEAD4_HI) begin
                            n_pend   = 2'd3;
                            n_expect = 1'b1;
                            if (value == pdu_pkg::U8_LEAD4_LO) n_lo = pdu_pkg::U8_F0_MIN;
                            if (value == pdu_pkg::U8_LEAD4_HI) n_hi = pdu_pkg::U8_F4_MAX;
                        end else begin
                            u8_bad = 1'b1;
                        end
                    end
                end else begin
                    if (r_expect) begin
                        u8_bad = (value < r_lo) || (value > r_hi);
                    end else begin
                        u8_bad = (value < pdu_pkg::U8_CONT_LO) || (value > pdu_pkg::U8_CONT_HI);
                    end
                    if (!u8_bad) begin
                        n_expect = 1'b0;
                        n_pend   = r_pend - 2'd1;
                    end
                end
                if (u8_bad) begin
                    n_err = pdu_pkg::ST_BAD_UTF8;
                end
            end
            if (n_err == pdu_pkg::ST_OK) begin
                o_push.entry.has_data = 1'b1;
                o_push.entry.data     = value;
            end
        end

        if (i_item.end_of_string) begin
            if (!n_seen) begin
                n_err = pdu_pkg::ST_EMPTY;
            end else begin
                if (n_phase == PH_HI || n_phase == PH_LO) begin
                    n_err = fault(n_err, pdu_pkg::ST_INCOMPLETE);
                end
                if (n_err == pdu_pkg::ST_OK && n_pend != 2'd0) begin
                    n_err = pdu_pkg::ST_BAD_UTF8;
                end
            end
            o_push.entry.has_status = 1'b1;
            o_push.entry.status     = n_err;
            n_phase  = PH_OUT;
            n_high   = '0;
            n_fdb    = 1'b0;
            n_err    = pdu_pkg::ST_OK;
            n_pend   = 2'd0;
            n_expect = 1'b0;
            n_lo     = pdu_pkg::U8_CONT_LO;
            n_hi     = pdu_pkg::U8_CONT_HI;
            n_seen   = 1'b0;
        end

        o_push.push = i_accept && (o_push.entry.has_data || o_push.entry.has_status);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OUT;
            r_high   <= '0;
            r_fdb    <= 1'b0;
            r_err    <= pdu_pkg::ST_OK;
            r_pend   <= 2'd0;
            r_expect <= 1'b0;
            r_lo     <= pdu_pkg::U8_CONT_LO;
            r_hi     <= pdu_pkg::U8_CONT_HI;
            r_seen   <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_high   <= n_high;
            r_fdb    <= n_fdb;
            r_err    <= n_err;
            r_pend   <= n_pend;
            r_expect <= n_expect;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_seen   <= n_seen;
        end
    end

endmodule

/* rtl/core/pdu_queue.sv */
// Queue: small FIFO of classified entries between front and back.
module pdu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pdu_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output pdu_pkg::t_entry o_head
);

    pdu_pkg::t_entry             r_mem [pdu_pkg::Q_DEPTH];
    logic [pdu_pkg::Q_AW-1:0]    r_wr, r_rd;
    logic [pdu_pkg::Q_AW:0]      r_cnt, n_cnt;

    assign o_full  = (r_cnt == (pdu_pkg::Q_AW+1)'(pdu_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push.push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/core/pdu_back.sv */
// Back end: splits queue entries into data and status results and holds the output register.
module pdu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  pdu_pkg::t_entry    i_head,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output pdu_pkg::t_out_item o_out_item
);

    logic               r_valid, n_valid;
    pdu_pkg::t_out_item r_item, n_item;
    logic               r_spend, n_spend;
    pdu_pkg::t_status   r_stat, n_stat;
    logic               load;

    function automatic pdu_pkg::t_out_item status_item(input pdu_pkg::t_status st);
        pdu_pkg::t_out_item r;
        r.item_kind  = pdu_pkg::KIND_STATUS;
        r.out_byte   = '0;
        r.status     = st;
        r.final_mark = 1'b1;
        return r;
    endfunction

    assign load = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        n_spend = r_spend;
        n_stat  = r_stat;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = 1'b0;
            if (r_spend) begin
                n_valid = 1'b1;
                n_item  = status_item(r_stat);
                n_spend = 1'b0;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_head.has_data) begin
                    n_item.item_kind  = pdu_pkg::KIND_DATA;
                    n_item.out_byte   = i_head.data;
                    n_item.status     = pdu_pkg::ST_OK;
                    n_item.final_mark = 1'b0;
                    n_spend           = i_head.has_status;
                    n_stat            = i_head.status;
                end else begin
                    n_item = status_item(i_head.status);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_stat <= n_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_spend <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_spend <= n_spend;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

/* rtl/core/percent_decoder_utf8_check.sv */
// Top level: percent decoder with strict UTF-8 check, front end, queue and back end.
//
//  channel  direction  handshake                        payload
//  in       input      i_in_valid / o_in_stall          i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_stall        o_out_item (t_out_item)
//
// The front end takes one item per cycle while the entry queue has room; its
// per-byte escape and UTF-8 state is formed combinationally and registered per accepted item.
// An item that ends a string and also delivers a data byte yields two results, data
// then status, which the back end sends in turn; other items yield one result or none.
// Reset is synchronous and active low; the queue comes out of reset empty.
// A stall on the output fills the queue; the input stalls only when it is full.
module percent_decoder_utf8_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pdu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pdu_pkg::t_out_item o_out_item
);

    pdu_pkg::t_push  push;
    pdu_pkg::t_entry head;
    logic            full, empty, pop;

    assign o_in_stall = full;

    pdu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && !full),
        .i_item   (i_in_item),
        .o_push   (push)
    );

    pdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    pdu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

/* bench/percent_decoder_utf8_check_test.sv */
// Testbench: random and directed percent-encoded strings checked against an in-bench decoder.
module percent_decoder_utf8_check_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    pdu_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    pdu_pkg::t_out_item o_out_item;

    percent_decoder_utf8_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // decoder state
    logic [1:0]       esc_phase;
    logic [3:0]       esc_high;
    logic             esc_high_bad;
    pdu_pkg::t_status first_error;
    logic [1:0]       cont_left;
    logic             cont_first;
    logic [7:0]       cont_first_lo;
    logic [7:0]       cont_first_hi;
    logic             got_byte;

    pdu_pkg::t_out_item pending_decoded[$];
    logic [7:0]         encoded[$];
    int                 mismatches = 0;
    int                 sent_items = 0;
    int                 cycles     = 0;
    bit                 quiet      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic append_expected(input pdu_pkg::t_out_item r);
        pending_decoded.insert(pending_decoded.size(), r);
    endtask

    task automatic append_encoded(input logic [7:0] b);
        encoded.insert(encoded.size(), b);
    endtask

    task automatic clear_decoder();
        esc_phase     = ESC_NONE;
        esc_high      = '0;
        esc_high_bad  = 1'b0;
        first_error   = pdu_pkg::ST_OK;
        cont_left     = '0;
        cont_first    = 1'b0;
        cont_first_lo = pdu_pkg::U8_CONT_LO;
        cont_first_hi = pdu_pkg::U8_CONT_HI;
        got_byte      = 1'b0;
    endtask

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
        return 5'd16;
    endfunction

    task automatic record_fault(input pdu_pkg::t_status code);
        if (first_error == pdu_pkg::ST_OK || first_error == pdu_pkg::ST_BAD_UTF8)
            first_error = code;
    endtask

    function automatic bit utf8_step(input logic [7:0] b);
        if (cont_left == 2'd0) begin
            if (b <= pdu_pkg::CH_DEL) return 1'b1;
            cont_first_lo = pdu_pkg::U8_CONT_LO;
            cont_first_hi = pdu_pkg::U8_CONT_HI;
            if (b >= pdu_pkg::U8_LEAD2_LO && b <= pdu_pkg::U8_LEAD2_HI) begin
                cont_left = 2'd1;
            end else if (b >= pdu_pkg::U8_LEAD3_LO && b <= pdu_pkg::U8_LEAD3_HI) begin
                cont_left = 2'd2;
                if (b == pdu_pkg::U8_LEAD3_LO) cont_first_lo = pdu_pkg::U8_E0_MIN;
                if (b == pdu_pkg::U8_ED) cont_first_hi = pdu_pkg::U8_ED_MAX;
            end else if (b >= pdu_pkg::U8_LEAD4_LO && b <= pdu_pkg::U8_LEAD4_HI) begin
                cont_left = 2'd3;
                if (b == pdu_pkg::U8_LEAD4_LO) cont_first_lo = pdu_pkg::U8_F0_MIN;
                if (b == pdu_pkg::U8_LEAD4_HI) cont_first_hi = pdu_pkg::U8_F4_MAX;
            end else begin
                return 1'b0;
            end
            cont_first = 1'b1;
            return 1'b1;
        end
        if (cont_first) begin
            if (b < cont_first_lo || b > cont_first_hi) return 1'b0;
        end else if (b < pdu_pkg::U8_CONT_LO || b > pdu_pkg::U8_CONT_HI) begin
            return 1'b0;
        end
        cont_first = 1'b0;
        cont_left  = cont_left - 2'd1;
        return 1'b1;
    endfunction

    task automatic percent_decode_step(input pdu_pkg::t_in_item it);
        logic             have;
        logic [7:0]       value;
        logic [4:0]       digit;
        pdu_pkg::t_status st;
        have  = 1'b0;
        value = '0;
        if (!it.no_byte) begin
            got_byte = 1'b1;
            if (esc_phase == ESC_HIGH) begin
                digit        = hex_of(it.in_byte);
                esc_high_bad = digit[4];
                esc_high     = digit[3:0];
                esc_phase    = ESC_LOW;
            end else if (esc_phase == ESC_LOW) begin
                digit     = hex_of(it.in_byte);
                esc_phase = ESC_NONE;
                if (esc_high_bad || digit[4]) begin
                    record_fault(pdu_pkg::ST_BAD_ESCAPE);
                end else begin
                    value = {esc_high, digit[3:0]};
                    have  = 1'b1;
                end
                esc_high_bad = 1'b0;
            end else if (it.in_byte == pdu_pkg::CH_PERCENT) begin
                esc_phase = ESC_HIGH;
            end else begin
                esc_phase = ESC_NONE;
                value     = it.in_byte;
                have      = 1'b1;
            end
            if (have) begin
                if (value < pdu_pkg::CH_SPACE || value == pdu_pkg::CH_DEL) begin
                    record_fault(pdu_pkg::ST_CONTROL);
                end else if (first_error == pdu_pkg::ST_OK && !utf8_step(value)) begin
                    first_error = pdu_pkg::ST_BAD_UTF8;
                end
                if (first_error == pdu_pkg::ST_OK)
                    append_expected('{pdu_pkg::KIND_DATA, value, pdu_pkg::ST_OK, 1'b0});
            end
        end
        if (it.end_of_string) begin
            if (!got_byte) begin
                st = pdu_pkg::ST_EMPTY;
            end else begin
                if (esc_phase == ESC_HIGH || esc_phase == ESC_LOW)
                    record_fault(pdu_pkg::ST_INCOMPLETE);
                if (first_error == pdu_pkg::ST_OK && cont_left != 2'd0)
                    first_error = pdu_pkg::ST_BAD_UTF8;
                st = first_error;
            end
            append_expected('{pdu_pkg::KIND_STATUS, 8'h00, st, 1'b1});
            clear_decoder();
        end
    endtask

    task automatic compare_decoded(input pdu_pkg::t_out_item want,
                                   input pdu_pkg::t_out_item got);
        if (got.item_kind !== want.item_kind) begin
            $error("item_kind expected %0d got %0d", want.item_kind, got.item_kind);
            mismatches++;
        end
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte expected %02h got %02h", want.out_byte, got.out_byte);
            mismatches++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.final_mark !== want.final_mark) begin
            $error("final_mark expected %0d got %0d", want.final_mark, got.final_mark);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) percent_decode_step(i_in_item);
            if (o_out_valid && !i_out_stall) begin
                if (pending_decoded.size() == 0) begin
                    $error("unexpected item %h", o_out_item);
                    mismatches++;
                end else begin
                    compare_decoded(pending_decoded.pop_front(), o_out_item);
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input pdu_pkg::t_in_item it);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_string(input bit end_alone);
        pdu_pkg::t_in_item it;
        foreach (encoded[i]) begin
            if ($urandom_range(0, 15) == 0) begin
                it = '{8'($urandom), 1'b1, 1'b0};
                send_item(it);
            end
            it.in_byte       = encoded[i];
            it.no_byte       = 1'b0;
            it.end_of_string = !end_alone && (i == encoded.size() - 1);
            send_item(it);
            sent_items++;
        end
        if (end_alone || encoded.size() == 0) begin
            it = '{8'($urandom), 1'b1, 1'b1};
            send_item(it);
            sent_items++;
        end
    endtask

    function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'h30 + n;
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // escape at random; a literal percent sign always goes escaped
    task automatic put_byte(input logic [7:0] b);
        if (b == pdu_pkg::CH_PERCENT || $urandom_range(0, 3) == 0) begin
            append_encoded(pdu_pkg::CH_PERCENT);
            append_encoded(hex_char(b[7:4], 1'($urandom_range(0, 1))));
            append_encoded(hex_char(b[3:0], 1'($urandom_range(0, 1))));
        end else begin
            append_encoded(b);
        end
    endtask

    task automatic add_code_point();
        logic [7:0] lead;
        case ($urandom_range(0, 5))
            0, 1: put_byte(pick_in(pdu_pkg::CH_SPACE, 8'h7E));
            2: begin
                put_byte(pick_in(pdu_pkg::U8_LEAD2_LO, pdu_pkg::U8_LEAD2_HI));
                put_byte(pick_in(pdu_pkg::U8_CONT_LO, pdu_pkg::U8_CONT_HI));
            end
            3: begin
                lead = ($urandom_range(0, 4) == 0) ? pdu_pkg::U8_ED :
                       pick_in(pdu_pkg::U8_LEAD3_LO, pdu_pkg::U8_LEAD3_HI);
                put_byte(lead);
                put_byte(pick_in(lead == pdu_pkg::U8_LEAD3_LO ? pdu_pkg::U8_E0_MIN :
                                                                pdu_pkg::U8_CONT_LO,
                                 lead == pdu_pkg::U8_ED ? pdu_pkg::U8_ED_MAX :
                                                          pdu_pkg::U8_CONT_HI));
                put_byte(pick_in(pdu_pkg::U8_CONT_LO, pdu_pkg::U8_CONT_HI));
            end
            default: begin
                lead = pick_in(pdu_pkg::U8_LEAD4_LO, pdu_pkg::U8_LEAD4_HI);
                put_byte(lead);
                put_byte(pick_in(lead == pdu_pkg::U8_LEAD4_LO ? pdu_pkg::U8_F0_MIN :
                                                                pdu_pkg::U8_CONT_LO,
                                 lead == pdu_pkg::U8_LEAD4_HI ? pdu_pkg::U8_F4_MAX :
                                                                pdu_pkg::U8_CONT_HI));
                put_byte(pick_in(pdu_pkg::U8_CONT_LO, pdu_pkg::U8_CONT_HI));
                put_byte(pick_in(pdu_pkg::U8_CONT_LO, pdu_pkg::U8_CONT_HI));
            end
        endcase
    endtask

    task automatic add_broken();
        logic [7:0] lead;
        case ($urandom_range(0, 6))
            0: put_byte($urandom_range(0, 1) ? pdu_pkg::CH_DEL : pick_in(8'h00, 8'h1F));
            1: begin
                lead = pick_in(pdu_pkg::U8_LEAD2_LO, pdu_pkg::U8_LEAD4_HI);
                put_byte(lead);
                if (lead >= pdu_pkg::U8_LEAD3_LO && $urandom_range(0, 1))
                    put_byte(pick_in(pdu_pkg::U8_CONT_LO, pdu_pkg::U8_CONT_HI));
            end
            2: begin
                put_byte(pick_in(pdu_pkg::U8_LEAD2_LO, pdu_pkg::U8_LEAD4_HI));
                put_byte($urandom_range(0, 1) ? pick_in(pdu_pkg::CH_SPACE, 8'h7E) :
                                                pick_in(8'hC0, 8'hFF));
            end
            3: put_byte($urandom_range(0, 1) ? pick_in(pdu_pkg::U8_CONT_LO, 8'hC1) :
                                               pick_in(8'hF5, 8'hFF));
            4: begin
                append_encoded(pdu_pkg::CH_PERCENT);
                append_encoded(8'($urandom));
                append_encoded(8'($urandom));
            end
            5: append_encoded(pdu_pkg::CH_PERCENT);
            default: begin
                case ($urandom_range(0, 3))
                    0: begin
                        put_byte(pdu_pkg::U8_LEAD3_LO);
                        put_byte(pick_in(pdu_pkg::U8_CONT_LO, 8'h9F));
                    end
                    1: begin
                        put_byte(pdu_pkg::U8_ED);
                        put_byte(pick_in(8'hA0, pdu_pkg::U8_CONT_HI));
                    end
                    2: begin
                        put_byte(pdu_pkg::U8_LEAD4_LO);
                        put_byte(pick_in(pdu_pkg::U8_CONT_LO, 8'h8F));
                    end
                    default: begin
                        put_byte(pdu_pkg::U8_LEAD4_HI);
                        put_byte(pick_in(8'h90, pdu_pkg::U8_CONT_HI));
                    end
                endcase
            end
        endcase
    endtask

    task automatic test_empty_and_ignored();
        encoded.delete();
        send_string(1'b1);
        send_item('{8'hFF, 1'b1, 1'b0});
        encoded = '{8'h41};
        send_string(1'b0);
    endtask

    task automatic test_escapes();
        encoded = '{pdu_pkg::CH_PERCENT, 8'h37, 8'h65};
        send_string(1'b1);
        encoded = '{pdu_pkg::CH_PERCENT, 8'h46, 8'h66};
        send_string(1'b0);
        encoded = '{pdu_pkg::CH_PERCENT, 8'h47};
        send_string(1'b1);
        encoded = '{pdu_pkg::CH_PERCENT, 8'h7A, 8'h7A};
        send_string(1'b0);
    endtask

    task automatic test_control_chars();
        encoded = '{8'h00};
        send_string(1'b0);
        encoded = '{8'hC0, pdu_pkg::CH_PERCENT, 8'h31, 8'h46};
        send_string(1'b0);
    endtask

    task automatic test_utf8_forms();
        encoded = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string(1'b0);
        encoded = '{pdu_pkg::U8_ED, 8'hA0};
        send_string(1'b0);
        encoded = '{8'hC3};
        send_string(1'b1);
    endtask

    task automatic test_random_strings(input int count);
        int stop_at;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            encoded.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(0, 8)) append_encoded(8'($urandom));
            end else begin
                repeat ($urandom_range(0, 8)) begin
                    if ($urandom_range(0, 11) == 0) add_broken();
                    else add_code_point();
                end
            end
            send_string($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_steady_stream();
        quiet = 1'b1;
        test_random_strings(200);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_decoded.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        clear_decoder();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_ignored();
        test_escapes();
        test_control_chars();
        test_utf8_forms();
        test_random_strings(1400);
        test_steady_stream();
        drain_results();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/pdu_pkg.sv
rtl/core/pdu_front.sv
rtl/core/pdu_queue.sv
rtl/core/pdu_back.sv
rtl/core/percent_decoder_utf8_check.sv
bench/percent_decoder_utf8_check_test.sv
